// File: sv/mexp_pkg.sv
// Shared constants and types of the modular exponentiation block.
`timescale 1ns / 1ps

package mexp_pkg;

  // Width of every payload field and of the modulus register.
  localparam int FIELD_W = 32;

  // Default operand width of the arithmetic.
  localparam int OPERAND_WIDTH_DEF = 32;

  // Modulus after reset.
  localparam logic [FIELD_W-1:0] MODULUS_RESET = 32'd3329;

  // The Fermat inverse raises the base to the modulus less this offset.
  localparam int FERMAT_OFFSET = 2;

  // Action codes.
  localparam logic ACT_EXP = 1'b0;
  localparam logic ACT_INV = 1'b1;

  // Sequencer to multiplier.
  typedef struct packed {
    logic start;
  } mm_ctrl_t;

  // Multiplier to sequencer.
  typedef struct packed {
    logic done;
  } mm_stat_t;

endpackage

// File: sv/mexp_channels.sv
// Valid/ready channel interfaces of the modular exponentiation block.
`timescale 1ns / 1ps

interface mexp_in_if;
  import mexp_pkg::*;

  logic               valid;
  logic               ready;
  logic               action;
  logic [FIELD_W-1:0] base;
  logic [FIELD_W-1:0] exponent;

  modport source (output valid, output action, output base, output exponent, input ready);
  modport sink   (input valid, input action, input base, input exponent, output ready);
endinterface

interface mexp_out_if;
  import mexp_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

interface mexp_cfg_if;
  import mexp_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] modulus;

  modport source (output valid, output modulus, input ready);
  modport sink   (input valid, input modulus, output ready);
endinterface

// File: sv/mexp_mulmod.sv
// Interleaved shift-and-add modular multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps

module mexp_mulmod #(
  parameter int W = mexp_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mexp_pkg::mm_ctrl_t  ctrl,
  input  logic [W-1:0]        op_a,
  input  logic [W-1:0]        op_b,
  input  logic [W-1:0]        m,
  output mexp_pkg::mm_stat_t  stat,
  output logic [W-1:0]        r
);
  import mexp_pkg::*;

  localparam int CW = $clog2(W);

  logic [W-1:0]  r_r, a_r, b_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;

  logic [W:0]    dbl, sum, m_ext;
  logic [W-1:0]  dbl_red, addend, r_step;

  // One step: r = 2r mod m, then add a mod m when the current bit of b is set.
  always_comb begin
    m_ext   = {1'b0, m};
    dbl     = {r_r, 1'b0};
    dbl_red = (dbl >= m_ext) ? W'(dbl - m_ext) : W'(dbl);
    addend  = b_r[W-1] ? a_r : '0;
    sum     = {1'b0, dbl_red} + {1'b0, addend};
    r_step  = (sum >= m_ext) ? W'(sum - m_ext) : W'(sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (ctrl.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == '0)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      r_r   <= '0;
      a_r   <= op_a;
      b_r   <= op_b;
      cnt_r <= CW'(W - 1);
    end else if (busy_r) begin
      r_r   <= r_step;
      b_r   <= {b_r[W-2:0], 1'b0};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign stat.done = done_r;
  assign r         = r_r;

endmodule

// File: sv/modular_exponentiation.sv
// Top level of the modular exponentiation block: sequencer, registers and channels.
//
//   Channel  Dir  Handshake        Payload
//   in_ch    in   valid / ready    action, base, exponent
//   out_ch   out  valid / ready    result
//   cfg_ch   in   valid / ready    modulus (always ready)
//
// A new item is only transferred in S_IDLE, once the previous one has left S_DONE.
// The time per item is set by the single shared modular multiplier, which
// consumes one multiplier bit per cycle, and by one pass through S_TEST per
// exponent bit. A zero exponent or a zero modulus goes from the transfer
// straight to S_DONE.
// Reset is synchronous and active low; it sets the modulus to 3329 and idles.
// The result waits in an output register, so a new item may be transferred
// while the previous result still stalls on out_ch; S_DONE only waits while an
// earlier result has not yet been transferred.

`timescale 1ns / 1ps

module modular_exponentiation #(
  parameter int OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  mexp_in_if.sink     in_ch,
  mexp_out_if.source  out_ch,
  mexp_cfg_if.sink    cfg_ch
);
  import mexp_pkg::*;

  localparam int W = OPERAND_WIDTH;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;  // base reduced mod m as 1 * base
  localparam logic [2:0] S_TEST = 3'd2;  // look at the lowest exponent bit
  localparam logic [2:0] S_MUL  = 3'd3;  // acc = acc * b mod m
  localparam logic [2:0] S_SQR  = 3'd4;  // b = b * b mod m
  localparam logic [2:0] S_DONE = 3'd5;  // hand acc to the output register

  logic [2:0]         state_r, state_nxt;
  logic [FIELD_W-1:0] modulus_r;
  logic [W-1:0]       e_r, e_nxt;
  logic [W-1:0]       b_r, b_nxt;
  logic [W-1:0]       acc_r, acc_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [FIELD_W-1:0] result_r, result_nxt;

  logic [W-1:0]       m_w;
  logic [W-1:0]       mm_a, mm_b, mm_r;
  mm_ctrl_t           mm_ctrl;
  mm_stat_t           mm_stat;

  // Users must change the modulus only while idle (unenforced); it is read directly.
  assign m_w = W'(modulus_r);

  mexp_mulmod #(
    .W (W)
  ) u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (mm_ctrl),
    .op_a  (mm_a),
    .op_b  (mm_b),
    .m     (m_w),
    .stat  (mm_stat),
    .r     (mm_r)
  );

  // Right-to-left square and multiply. The final squaring is skipped once no
  // exponent bits remain, since its value would never be used.
  always_comb begin
    state_nxt     = state_r;
    e_nxt         = e_r;
    b_nxt         = b_r;
    acc_nxt       = acc_r;
    mm_ctrl.start = 1'b0;
    mm_a          = acc_r;
    mm_b          = b_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    result_nxt    = result_r;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.action == ACT_INV) begin
            e_nxt = m_w - W'(FERMAT_OFFSET);
          end else begin
            e_nxt = W'(in_ch.exponent);
          end
          acc_nxt = W'(1);
          if (m_w == '0) begin
            // Nothing can be reduced by a zero modulus.
            acc_nxt   = '0;
            state_nxt = S_DONE;
          end else if (e_nxt == '0) begin
            // A zero exponent yields one, left unreduced.
            state_nxt = S_DONE;
          end else begin
            mm_ctrl.start = 1'b1;
            mm_a          = W'(1);
            mm_b          = W'(in_ch.base);
            state_nxt     = S_RED;
          end
        end
      end
      S_RED: begin
        if (mm_stat.done) begin
          b_nxt     = mm_r;
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        mm_ctrl.start = 1'b1;
        if (e_r[0]) begin
          mm_a      = acc_r;
          state_nxt = S_MUL;
        end else begin
          mm_a      = b_r;
          state_nxt = S_SQR;
        end
      end
      S_MUL: begin
        if (mm_stat.done) begin
          acc_nxt = mm_r;
          if (e_r[W-1:1] == '0) begin
            state_nxt = S_DONE;
          end else begin
            mm_ctrl.start = 1'b1;
            mm_a          = b_r;
            state_nxt     = S_SQR;
          end
        end
      end
      S_SQR: begin
        if (mm_stat.done) begin
          b_nxt     = mm_r;
          e_nxt     = e_r >> 1;
          state_nxt = S_TEST;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          result_nxt    = FIELD_W'(acc_r);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      modulus_r   <= MODULUS_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) begin
        modulus_r <= cfg_ch.modulus;
      end
    end
  end

  always_ff @(posedge clk) begin
    e_r      <= e_nxt;
    b_r      <= b_nxt;
    acc_r    <= acc_nxt;
    result_r <= result_nxt;
  end

  assign in_ch.ready   = (state_r == S_IDLE);
  assign out_ch.valid  = out_valid_r;
  assign out_ch.result = result_r;
  assign cfg_ch.ready  = 1'b1;

endmodule

// File: sv/mexp_checker.sv
// Port-level assertions for the modular exponentiation block, bound to its top level.
`timescale 1ns / 1ps

module mexp_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [mexp_pkg::FIELD_W-1:0] result
);
  import mexp_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(result))
    else $error("result changed while stalled");

  // Once an item is transferred the block is busy with it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready again straight after an input transfer");

  // A new result only appears from a busy block.
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while the block was idle");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .result    (out_ch.result)
);

// File: tb/sv/modular_exponentiation_tb.sv
// Self-checking testbench for the modular exponentiation block.
`timescale 1ns / 1ps

module modular_exponentiation_tb;
  import mexp_pkg::*;

  // Tracks the modulus as the block should hold it and keeps the powers that are
  // still owed on the result channel, oldest first.
  class mexp_scoreboard;
    logic [FIELD_W-1:0] modulus;
    logic [FIELD_W-1:0] awaited_powers[$];
    int                 errors;
    int                 items;
    int                 inverses;
    int                 results;

    function new();
      modulus  = MODULUS_RESET;
      errors   = 0;
      items    = 0;
      inverses = 0;
      results  = 0;
    endfunction

    function void set_modulus(input logic [FIELD_W-1:0] value);
      modulus = value;
    endfunction

    // Right-to-left square-and-multiply with every product reduced exactly.
    function logic [FIELD_W-1:0] mod_power(input logic act, input logic [FIELD_W-1:0] b,
                                           input logic [FIELD_W-1:0] e);
      logic [63:0]        m;
      logic [63:0]        acc;
      logic [63:0]        sq;
      logic [FIELD_W-1:0] ex;
      m = {32'd0, modulus};
      if (m == 0) begin
        return '0;
      end
      ex  = (act == ACT_INV) ? modulus - FERMAT_OFFSET : e;
      acc = 64'd1;
      sq  = {32'd0, b} % m;
      while (ex != 0) begin
        if (ex[0]) begin
          acc = ((acc % m) * sq) % m;
        end
        sq = (sq * sq) % m;
        ex = ex >> 1;
      end
      return acc[FIELD_W-1:0];
    endfunction

    function void note_item(input logic act, input logic [FIELD_W-1:0] b,
                            input logic [FIELD_W-1:0] e);
      awaited_powers.push_back(mod_power(act, b, e));
      items++;
      if (act == ACT_INV) begin
        inverses++;
      end
    endfunction

    function void check_result(input logic [FIELD_W-1:0] actual);
      logic [FIELD_W-1:0] want;
      results++;
      if (awaited_powers.size() == 0) begin
        $error("result arrived with none awaited: actual %h", actual);
        errors++;
      end else begin
        want = awaited_powers.pop_front();
        if (actual !== want) begin
          $error("result mismatch: expected %h, actual %h", want, actual);
          errors++;
        end
      end
    endfunction

    function void check_drained();
      if (awaited_powers.size() != 0) begin
        $error("%0d results never arrived", awaited_powers.size());
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  mexp_in_if  in_if();
  mexp_out_if out_if();
  mexp_cfg_if cfg_if();

  modular_exponentiation uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  mexp_scoreboard sb = new();

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mostly short pauses, now and then a long one; runs of zeros give stretches
  // with no idling at all.
  function automatic int pause_cycles();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      return 0;
    end else if (pick < 88) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 60);
  endfunction

  // Both transfers are observed at the same edge. A result can never belong to
  // an item transferred at that very edge, so the result is checked first.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        sb.check_result(out_if.result);
      end
      if (in_if.valid && in_if.ready) begin
        sb.note_item(in_if.action, in_if.base, in_if.exponent);
      end
    end
  end

  // The receiver accepts for a random run of cycles, then stalls for a random gap.
  initial begin
    int hold;
    int gap;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      hold = $urandom_range(1, 12);
      out_if.ready <= 1'b1;
      repeat (hold) @(posedge clk);
      gap = pause_cycles();
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Presents one item, waits for its transfer, then perhaps leaves a gap. When no
  // gap follows, valid simply stays high for the next item.
  task automatic send_item(input logic act, input logic [FIELD_W-1:0] b,
                           input logic [FIELD_W-1:0] e);
    int gap;
    in_if.valid    <= 1'b1;
    in_if.action   <= act;
    in_if.base     <= b;
    in_if.exponent <= e;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    gap = pause_cycles();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Lowers valid and waits until every owed result has been transferred, which
  // leaves the block idle since each item yields exactly one result.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.awaited_powers.size() != 0) @(posedge clk);
  endtask

  task automatic write_modulus(input logic [FIELD_W-1:0] value);
    cfg_if.valid   <= 1'b1;
    cfg_if.modulus <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    sb.set_modulus(value);
  endtask

  // A random item, biased towards the awkward bases (zero, the modulus and the
  // value just below it) and spread over every exponent length.
  task automatic send_random_item();
    logic               act;
    logic [FIELD_W-1:0] b;
    logic [FIELD_W-1:0] e;
    logic [63:0]        wide;
    int                 len;
    int                 pick;
    act  = ($urandom_range(0, 3) == 0) ? ACT_INV : ACT_EXP;
    pick = $urandom_range(0, 9);
    case (pick)
      0:       b = '0;
      1:       b = sb.modulus - 1;
      2:       b = sb.modulus;
      3:       b = $urandom_range(0, 15);
      default: b = $urandom;
    endcase
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      e = '0;
    end else if (pick == 1) begin
      e = '1;
    end else begin
      len  = $urandom_range(1, FIELD_W);
      wide = ({32'd0, $urandom} | (64'd1 << (len - 1))) & ((64'd1 << len) - 1);
      e    = wide[FIELD_W-1:0];
    end
    send_item(act, b, e);
  endtask

  // One setting of the modulus: a few fixed items that hit the zero exponent, the
  // zero base under inversion and a base equal to the modulus, then random items.
  task automatic run_setting(input logic [FIELD_W-1:0] m, input int count);
    write_modulus(m);
    send_item(ACT_EXP, $urandom, '0);
    send_item(ACT_INV, '0, $urandom);
    send_item(ACT_EXP, m, $urandom);
    repeat (count) send_random_item();
    drain();
  endtask

  initial begin
    int settings;
    settings = 1;
    rst_n          <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.action   <= ACT_EXP;
    in_if.base     <= '0;
    in_if.exponent <= '0;
    cfg_if.valid   <= 1'b0;
    cfg_if.modulus <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items under the modulus left by reset.
    send_item(ACT_EXP, 32'd0, 32'd0);
    send_item(ACT_EXP, 32'd0, 32'd1);
    send_item(ACT_EXP, 32'hFFFF_FFFF, 32'd0);
    send_item(ACT_EXP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(ACT_EXP, 32'd1, 32'hFFFF_FFFF);
    send_item(ACT_EXP, 32'd3329, 32'd7);
    send_item(ACT_EXP, 32'd3328, 32'd2);
    send_item(ACT_EXP, 32'd3328, 32'd3);
    send_item(ACT_EXP, 32'd17, 32'd3328);
    send_item(ACT_EXP, 32'd2, 32'h8000_0000);
    send_item(ACT_EXP, 32'hAAAA_AAAA, 32'h5555_5555);
    send_item(ACT_EXP, 32'h5555_5555, 32'hAAAA_AAAA);
    send_item(ACT_INV, 32'd0, 32'd0);
    send_item(ACT_INV, 32'd1, 32'hFFFF_FFFF);
    send_item(ACT_INV, 32'd2, 32'h1234_5678);
    send_item(ACT_INV, 32'd3328, 32'd0);
    send_item(ACT_INV, 32'hFFFF_FFFF, 32'd0);
    send_item(ACT_INV, 32'd3329, 32'd0);
    send_item(ACT_INV, 32'h1234_5678, 32'h9ABC_DEF0);
    repeat (6) send_random_item();
    drain();

    // The smallest supported modulus, then zero and one, which the block still
    // has to handle, then the largest values and a spread in between.
    run_setting(32'd2, 20);
    run_setting(32'd0, 15);
    run_setting(32'd1, 15);
    run_setting(32'hFFFF_FFFF, 23);
    run_setting(32'hFFFF_FFFB, 23);
    run_setting(32'd65537, 23);
    run_setting(32'd3, 20);
    run_setting(32'd7681, 23);
    run_setting($urandom | 32'h8000_0001, 23);
    run_setting($urandom_range(4, 1000), 23);
    settings += 10;

    // Any stray result would still arrive during this wait.
    repeat (2200) @(posedge clk);
    sb.check_drained();

    $display("Run covered %0d items (%0d Fermat inverses) under %0d modulus settings,",
             sb.items, sb.inverses, settings);
    $display("with %0d results checked against the predicted powers.", sb.results);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Far beyond the slowest correct run: every item at full exponent length with
  // the longest gaps and stalls on both sides.
  initial begin
    #15_000_000;
    $display("Timed out before all results had arrived.");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
